### rtl/constant_divisor_divide_remainder_assert.svh
// Assertion macros for the constant divisor divider.
// Each macro expects clk and rst_n in scope.
`ifndef CONSTANT_DIVISOR_DIVIDE_REMAINDER_ASSERT_SVH
`define CONSTANT_DIVISOR_DIVIDE_REMAINDER_ASSERT_SVH

// Same-cycle implication.
`define CDD_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define CDD_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### rtl/cdd_pkg.sv
// ----------------------------------------------------------------------------
// cdd_pkg
// Shared widths, register indexes and types of the constant divisor divider.
// ----------------------------------------------------------------------------
`default_nettype none

package cdd_pkg;

  localparam int DATA_WIDTH = 64;
  localparam int HALF_WIDTH = 32;
  localparam int LEN_W      = 7;   // bit length of the divisor, 0..64
  localparam int STEP_W     = 8;   // reciprocal steps, up to 128

  localparam logic [1:0] CFG_DIVISOR = 2'd0;
  localparam logic [1:0] CFG_SIGNED  = 2'd1;
  localparam logic [1:0] CFG_WIDE    = 2'd2;

  // Divisor as seen by the datapath.
  typedef struct packed {
    logic [DATA_WIDTH-1:0] da;    // divisor magnitude
    logic                  dneg;
    logic                  zero;
    logic                  sgn;
    logic                  wide;
  } dcfg_t;

  // Reciprocal: m = 2^64 + m_lo = floor((2^(64+len)-1)/da).
  typedef struct packed {
    logic [DATA_WIDTH-1:0] m_lo;
    logic [LEN_W-1:0]      len;
    logic                  busy;
  } recip_t;

  function automatic logic [DATA_WIDTH-1:0] op_mask(input logic wide);
    return wide ? {DATA_WIDTH{1'b1}} : {{(DATA_WIDTH-HALF_WIDTH){1'b0}}, {HALF_WIDTH{1'b1}}};
  endfunction

endpackage

`default_nettype wire

### rtl/cdd_in_if.sv
// ----------------------------------------------------------------------------
// cdd_in_if
// Numerator channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface cdd_in_if import cdd_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [DATA_WIDTH-1:0] numerator_bits;
  modport source (output valid, output numerator_bits, input ready);
  modport sink   (input valid, input numerator_bits, output ready);
endinterface

`default_nettype wire

### rtl/cdd_out_if.sv
// ----------------------------------------------------------------------------
// cdd_out_if
// Result channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface cdd_out_if import cdd_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [DATA_WIDTH-1:0] quotient_bits;
  logic [DATA_WIDTH-1:0] remainder_bits;
  logic                  divide_by_zero;
  modport source (output valid, output quotient_bits, output remainder_bits,
                  output divide_by_zero, input ready);
  modport sink   (input valid, input quotient_bits, input remainder_bits,
                  input divide_by_zero, output ready);
endinterface

`default_nettype wire

### rtl/cdd_cfg_if.sv
// ----------------------------------------------------------------------------
// cdd_cfg_if
// Register write channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface cdd_cfg_if import cdd_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [1:0]            index;
  logic [DATA_WIDTH-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### rtl/cdd_recip.sv
// ----------------------------------------------------------------------------
// cdd_recip
// Derives the reciprocal of the divisor magnitude: bit-length scan, then
// restoring division of an all-ones word, one bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module cdd_recip import cdd_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  input  wire logic [DATA_WIDTH-1:0] da,
  input  wire logic                  zero,
  output recip_t                     rc
);

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DIV} state_t;

  state_t                state_r, state_nxt;
  logic [DATA_WIDTH-1:0] t_r, t_nxt;
  logic [LEN_W-1:0]      len_r, len_nxt;
  logic [STEP_W-1:0]     k_r, k_nxt;
  logic [DATA_WIDTH-1:0] rem_r, rem_nxt;
  logic [DATA_WIDTH-1:0] q_r, q_nxt;
  logic [DATA_WIDTH:0]   rem2;
  logic [DATA_WIDTH:0]   rem_sub;
  logic                  ge;

  assign rem2    = {rem_r, 1'b1};
  assign ge      = rem2 >= {1'b0, da};
  assign rem_sub = rem2 - {1'b0, da};

  always_comb begin
    state_nxt = state_r;
    t_nxt     = t_r;
    len_nxt   = len_r;
    k_nxt     = k_r;
    rem_nxt   = rem_r;
    q_nxt     = q_r;
    if (start) begin
      t_nxt     = da;
      len_nxt   = '0;
      state_nxt = zero ? ST_IDLE : ST_SCAN;
    end else begin
      case (state_r)
        ST_SCAN: begin
          if (t_r != '0) begin
            t_nxt   = t_r >> 1;
            len_nxt = len_r + LEN_W'(1);
          end else begin
            k_nxt     = STEP_W'(DATA_WIDTH) + STEP_W'(len_r);
            rem_nxt   = '0;
            q_nxt     = '0;
            state_nxt = ST_DIV;
          end
        end
        ST_DIV: begin
          rem_nxt = ge ? rem_sub[DATA_WIDTH-1:0] : rem2[DATA_WIDTH-1:0];
          q_nxt   = {q_r[DATA_WIDTH-2:0], ge};
          k_nxt   = k_r - STEP_W'(1);
          if (k_r == STEP_W'(1)) state_nxt = ST_IDLE;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    t_r   <= t_nxt;
    len_r <= len_nxt;
    k_r   <= k_nxt;
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
  end

  assign rc.m_lo = q_r;
  assign rc.len  = len_r;
  assign rc.busy = (state_r != ST_IDLE);

endmodule

`default_nettype wire

### rtl/cdd_pipe.sv
// ----------------------------------------------------------------------------
// cdd_pipe
// Six-stage divide datapath: magnitude, multiply, estimate, back-multiply,
// correct, sign and mask.
// ----------------------------------------------------------------------------
`default_nettype none

module cdd_pipe import cdd_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  adv,
  input  wire logic                  in_fire,
  input  wire logic [DATA_WIDTH-1:0] numerator,
  input  wire dcfg_t                 dc,
  input  wire recip_t                rc,
  output logic                       out_valid,
  output logic [DATA_WIDTH-1:0]      quotient,
  output logic [DATA_WIDTH-1:0]      remainder,
  output logic                       dz
);

  localparam int H = HALF_WIDTH;
  localparam int W = DATA_WIDTH;

  logic [5:0]   v_r;
  logic [W-1:0] mask;

  // stage 1
  logic [W-1:0] n1, na1_nxt, na1_r;
  logic         nneg1_nxt, nneg1_r, qneg1_r;
  // stage 2
  logic [W-1:0] pp0_r, pp1_r, pp2_r, pp3_r, na2_r;
  logic         nneg2_r, qneg2_r;
  // stage 3
  logic [2*W:0] sum3;
  logic [W:0]   hi3;
  logic [W-1:0] q3_r, na3_r;
  logic         nneg3_r, qneg3_r;
  // stage 4
  logic [W-1:0] pll_r, plh_r, phl_r, q4_r, na4_r;
  logic         nneg4_r, qneg4_r;
  // stage 5
  logic [H-1:0] cross5;
  logic [W-1:0] prod5, r5, q5_r, r5_r;
  logic         ge5, nneg5_r, qneg5_r;
  // stage 6
  logic [W-1:0] q6_nxt, r6_nxt, q6_r, r6_r;

  assign mask = op_mask(dc.wide);

  assign n1        = numerator & mask;
  assign nneg1_nxt = dc.sgn && (dc.wide ? n1[W-1] : n1[H-1]);
  assign na1_nxt   = nneg1_nxt ? ((W'(0) - n1) & mask) : n1;

  assign sum3 = {na2_r, {W{1'b0}}} + {{(W+1){1'b0}}, pp0_r}
              + {{(H+1){1'b0}}, pp1_r, {H{1'b0}}} + {{(H+1){1'b0}}, pp2_r, {H{1'b0}}}
              + {1'b0, pp3_r, {W{1'b0}}};
  assign hi3  = sum3[2*W:W];

  assign cross5 = plh_r[H-1:0] + phl_r[H-1:0];
  assign prod5  = pll_r + {cross5, {H{1'b0}}};
  assign r5     = na4_r - prod5;
  assign ge5    = r5 >= dc.da;

  assign q6_nxt = (qneg5_r ? (W'(0) - q5_r) : q5_r) & mask;
  assign r6_nxt = (nneg5_r ? (W'(0) - r5_r) : r5_r) & mask;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[4:0], in_fire};
    end
    if (adv) begin
      // stage 1: magnitude and signs
      na1_r   <= na1_nxt;
      nneg1_r <= nneg1_nxt;
      qneg1_r <= nneg1_nxt ^ dc.dneg;
      // stage 2: partial products of na * m_lo
      pp0_r   <= W'(na1_r[H-1:0] * rc.m_lo[H-1:0]);
      pp1_r   <= W'(na1_r[H-1:0] * rc.m_lo[W-1:H]);
      pp2_r   <= W'(na1_r[W-1:H] * rc.m_lo[H-1:0]);
      pp3_r   <= W'(na1_r[W-1:H] * rc.m_lo[W-1:H]);
      na2_r   <= na1_r;
      nneg2_r <= nneg1_r;
      qneg2_r <= qneg1_r;
      // stage 3: quotient estimate, low by at most one
      q3_r    <= W'(hi3 >> rc.len);
      na3_r   <= na2_r;
      nneg3_r <= nneg2_r;
      qneg3_r <= qneg2_r;
      // stage 4: low word of estimate * divisor
      pll_r   <= W'(q3_r[H-1:0] * dc.da[H-1:0]);
      plh_r   <= W'(q3_r[H-1:0] * dc.da[W-1:H]);
      phl_r   <= W'(q3_r[W-1:H] * dc.da[H-1:0]);
      q4_r    <= q3_r;
      na4_r   <= na3_r;
      nneg4_r <= nneg3_r;
      qneg4_r <= qneg3_r;
      // stage 5: correct
      q5_r    <= q4_r + W'(ge5);
      r5_r    <= ge5 ? (r5 - dc.da) : r5;
      nneg5_r <= nneg4_r;
      qneg5_r <= qneg4_r;
      // stage 6: signs, mask, zero divisor
      q6_r    <= dc.zero ? '0 : q6_nxt;
      r6_r    <= dc.zero ? '0 : r6_nxt;
    end
  end

  assign out_valid = v_r[5];
  assign quotient  = q6_r;
  assign remainder = r6_r;
  assign dz        = dc.zero;

endmodule

`default_nettype wire

### rtl/constant_divisor_divide_remainder.sv
// ----------------------------------------------------------------------------
// constant_divisor_divide_remainder
// Divides a stream of numerators by a configured constant divisor.
// ----------------------------------------------------------------------------
// Channels: in_ch transfers one numerator, out_ch transfers one result
// (quotient, remainder, divide_by_zero) per numerator in order, cfg_ch
// writes register index 0 (divisor), 1 (signed mode) or 2 (wide mode).
// Throughput: one numerator per cycle through the six-stage pipeline
// while no result is stalled and the reciprocal unit is idle.
// Each register write, and reset, starts the reciprocal unit: a bit-length
// scan of the divisor magnitude followed by 64+len division steps;
// in_ch.ready stays low meanwhile.
// Write registers only with the pipeline empty.
// Reset: divisor 1, unsigned, 64-bit; all stage valid bits clear.
// Receiver stall: the whole pipeline holds while a result waits and the
// receiver is not ready; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module constant_divisor_divide_remainder import cdd_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  cdd_in_if.sink    in_ch,
  cdd_out_if.source out_ch,
  cdd_cfg_if.sink   cfg_ch
);

  `include "constant_divisor_divide_remainder_assert.svh"

  logic [DATA_WIDTH-1:0] divisor_r;
  logic                  signed_r;
  logic                  wide_r;
  logic                  start_r;
  logic                  cfg_fire;
  logic [DATA_WIDTH-1:0] mask;
  logic [DATA_WIDTH-1:0] d;
  logic                  dneg;
  dcfg_t                 dc;
  recip_t                rc;
  logic                  adv;
  logic                  in_fire;
  logic                  out_valid;

  assign cfg_ch.ready = 1'b1;
  assign cfg_fire     = cfg_ch.valid && cfg_ch.ready;

  // Hold the registers; a write restarts the reciprocal next cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      divisor_r <= DATA_WIDTH'(1);
      signed_r  <= 1'b0;
      wide_r    <= 1'b1;
      start_r   <= 1'b1;
    end else begin
      start_r <= cfg_fire;
      if (cfg_fire) begin
        case (cfg_ch.index)
          CFG_DIVISOR: divisor_r <= cfg_ch.data;
          CFG_SIGNED:  signed_r  <= cfg_ch.data[0];
          CFG_WIDE:    wide_r    <= cfg_ch.data[0];
          default: ;
        endcase
      end
    end
  end

  // Divisor magnitude in the operand width.
  assign mask    = op_mask(wide_r);
  assign d       = divisor_r & mask;
  assign dneg    = signed_r && (wide_r ? d[DATA_WIDTH-1] : d[HALF_WIDTH-1]);
  assign dc.da   = dneg ? ((DATA_WIDTH'(0) - d) & mask) : d;
  assign dc.dneg = dneg;
  assign dc.zero = (d == '0);
  assign dc.sgn  = signed_r;
  assign dc.wide = wide_r;

  cdd_recip u_recip (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start_r),
    .da    (dc.da),
    .zero  (dc.zero),
    .rc    (rc)
  );

  // Advance the pipeline unless a finished result is stalled.
  assign adv         = !out_valid || out_ch.ready;
  assign in_ch.ready = adv && !rc.busy && !start_r;
  assign in_fire     = in_ch.valid && in_ch.ready;

  cdd_pipe u_pipe (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_fire   (in_fire),
    .numerator (in_ch.numerator_bits),
    .dc        (dc),
    .rc        (rc),
    .out_valid (out_valid),
    .quotient  (out_ch.quotient_bits),
    .remainder (out_ch.remainder_bits),
    .dz        (out_ch.divide_by_zero)
  );

  assign out_ch.valid = out_valid;

  `CDD_ASSERT_IMP(a_no_take_busy, in_fire, !rc.busy && !start_r)
  `CDD_ASSERT_IMP(a_zero_gives_zero, out_valid && out_ch.divide_by_zero,
                  out_ch.quotient_bits == '0 && out_ch.remainder_bits == '0)
  `CDD_ASSERT_IMP(a_rem_below_div, out_valid && !signed_r && !dc.zero,
                  out_ch.remainder_bits < dc.da)
  `CDD_ASSERT_NXT(a_narrow_upper_zero, out_valid && !wide_r && out_ch.ready && !cfg_fire,
                  !out_valid || (out_ch.quotient_bits[DATA_WIDTH-1:HALF_WIDTH] == '0
                  && out_ch.remainder_bits[DATA_WIDTH-1:HALF_WIDTH] == '0))

endmodule

`default_nettype wire
